// ===== hw/rtl/crf_pkg.sv =====
// shared types and constants for the clipped rectangle fill frame store
package crf_pkg;

    // coordinate and address widths fit a 1024 x 1024 screen; COUNT_W holds at most 131071 pixels
    localparam int COORD_W     = 11;
    localparam int ADDR_W      = 20;
    localparam int COLOR_W     = 16;
    localparam int COUNT_W     = 17;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_PIXEL  = 2'd0,
        OP_RECT   = 2'd1,
        OP_SCREEN = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        JOB_NOTE = 2'd0,
        JOB_WALK = 2'd1,
        JOB_READ = 2'd2
    } job_kind_t;

    // one classified request, clipped to the screen
    typedef struct packed {
        job_kind_t            kind;
        logic [COORD_W-1:0]   x0;
        logic [COORD_W-1:0]   x1;
        logic [COORD_W-1:0]   y0;
        logic [COORD_W-1:0]   y1;
        logic [ADDR_W-1:0]    base;
        logic [COLOR_W-1:0]   color;
        logic [COUNT_W-1:0]   count;
        logic                 outside;
    } job_t;

endpackage

// ===== hw/rtl/crf_ram.sv =====
// generic single port ram with registered read
module crf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                       wdata,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
        rdata_reg <= mem_array[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/crf_front.sv =====
// front end: accepts requests, clips them to the screen and classifies them
module crf_front
    import crf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 256,
    parameter int SCREEN_HEIGHT = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         op,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] rect_width,
    input  logic signed [15:0] rect_height,
    input  logic [15:0]        pixel_color,
    input  logic               hold,
    input  logic               q_full,
    output logic               job_push,
    output job_t               job
);

    localparam logic signed [17:0] WS = 18'(SCREEN_WIDTH);
    localparam logic signed [17:0] HS = 18'(SCREEN_HEIGHT);

    logic               valid_reg, valid_next;
    job_t               job_reg, job_next;
    logic               accept;
    logic signed [15:0] ex, ey, ew, eh;
    logic signed [17:0] sx, sy, x_end, y_end, x0c, y0c, x1c, y1c, dx, dy;
    logic               nonpos, empty;
    logic [21:0]        area, base_full;

    // effective rectangle: pixel and read are 1x1, screen fill is the whole screen
    always_comb
    begin
        case (op_t'(op))
            OP_RECT:
            begin
                ex = pos_x;
                ey = pos_y;
                ew = rect_width;
                eh = rect_height;
            end
            OP_SCREEN:
            begin
                ex = '0;
                ey = '0;
                ew = 16'(SCREEN_WIDTH);
                eh = 16'(SCREEN_HEIGHT);
            end
            default:
            begin
                ex = pos_x;
                ey = pos_y;
                ew = 16'sd1;
                eh = 16'sd1;
            end
        endcase
    end

    // exact clipping in 18 bits, so no edge ever wraps
    always_comb
    begin
        sx     = {{2{ex[15]}}, ex};
        sy     = {{2{ey[15]}}, ey};
        x_end  = sx + {{2{ew[15]}}, ew};
        y_end  = sy + {{2{eh[15]}}, eh};
        x0c    = sx[17] ? '0 : sx;
        y0c    = sy[17] ? '0 : sy;
        x1c    = (x_end > WS) ? WS : x_end;
        y1c    = (y_end > HS) ? HS : y_end;
        dx     = x1c - x0c;
        dy     = y1c - y0c;
        nonpos = (ew <= 16'sd0) || (eh <= 16'sd0);
        empty  = (x1c <= x0c) || (y1c <= y0c);
        area      = 22'(dx[COORD_W-1:0]) * 22'(dy[COORD_W-1:0]);
        base_full = 22'(y0c[COORD_W-1:0]) * 22'(SCREEN_WIDTH) + 22'(x0c[COORD_W-1:0]);
    end

    always_comb
    begin
        job_next         = job_reg;
        job_next.x0      = x0c[COORD_W-1:0];
        job_next.x1      = x1c[COORD_W-1:0];
        job_next.y0      = y0c[COORD_W-1:0];
        job_next.y1      = y1c[COORD_W-1:0];
        job_next.base    = base_full[ADDR_W-1:0];
        job_next.color   = pixel_color;
        job_next.count   = '0;
        job_next.outside = 1'b0;
        if (nonpos)
        begin
            job_next.kind = JOB_NOTE;
        end
        else if (empty)
        begin
            job_next.kind    = JOB_NOTE;
            job_next.outside = 1'b1;
        end
        else if (op_t'(op) == OP_READ)
        begin
            job_next.kind = JOB_READ;
        end
        else
        begin
            job_next.kind  = JOB_WALK;
            job_next.count = area[COUNT_W-1:0];
        end
    end

    assign full     = hold || (valid_reg && q_full);
    assign accept   = push && !full;
    assign job_push = valid_reg && !q_full;
    assign job      = job_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (job_push)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

    // a walk job always covers at least one pixel
    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && job_reg.kind == JOB_WALK) |->
            (job_reg.x1 > job_reg.x0) && (job_reg.y1 > job_reg.y0))
        else $error("walk job with empty extent");

endmodule

// ===== hw/rtl/crf_queue.sv =====
// short job queue between front end and back end
module crf_queue
    import crf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wdata,
    output logic full,
    output logic valid,
    input  logic pop,
    output job_t rdata
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    job_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = pop && valid;
    assign rdata   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (do_push && !do_pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== hw/rtl/crf_back.sv =====
// back end: walks fills into the frame store, serves reads, holds the result
module crf_back
    import crf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 256,
    parameter int SCREEN_HEIGHT = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  job_t         q_job,
    output logic         q_pop,
    output logic         clearing,
    output logic         empty,
    input  logic         pop,
    output logic [15:0]  read_color,
    output logic [16:0]  pixels_written,
    output logic         outside
);

    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int RAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_READ,
        ST_RDATA
    } state_t;

    state_t              state_reg, state_next;
    logic [COORD_W-1:0]  col_reg, col_next;
    logic [COORD_W-1:0]  row_reg, row_next;
    logic [COORD_W-1:0]  x0_reg, x0_next;
    logic [COORD_W-1:0]  x1_reg, x1_next;
    logic [COORD_W-1:0]  y1_reg, y1_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic                report_reg, report_next;
    logic                out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]  out_color_reg, out_color_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic                out_outside_reg, out_outside_next;
    logic                mem_we;
    logic [COLOR_W-1:0]  mem_rdata;
    logic                out_free, last_col, last_row;
    logic [ADDR_W-1:0]   next_base;

    crf_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .addr  (addr_reg[RAW-1:0]),
        .wdata (color_reg),
        .rdata (mem_rdata)
    );

    assign mem_we    = (state_reg == ST_WALK) || (state_reg == ST_CLEAR);
    assign out_free  = !out_valid_reg || pop;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid && out_free;
    assign last_col  = (COORD_W'(col_reg + 1'b1) == x1_reg);
    assign last_row  = (COORD_W'(row_reg + 1'b1) == y1_reg);
    assign next_base = ADDR_W'(base_reg + ADDR_W'(SCREEN_WIDTH));
    assign clearing  = (state_reg == ST_CLEAR);

    assign empty          = !out_valid_reg;
    assign read_color     = out_color_reg;
    assign pixels_written = out_count_reg;
    assign outside        = out_outside_reg;

    always_comb
    begin
        state_next       = state_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        x0_next          = x0_reg;
        x1_next          = x1_reg;
        y1_next          = y1_reg;
        addr_next        = addr_reg;
        base_next        = base_reg;
        color_next       = color_reg;
        count_next       = count_reg;
        report_next      = report_reg;
        out_valid_next   = out_valid_reg;
        out_color_next   = out_color_reg;
        out_count_next   = out_count_reg;
        out_outside_next = out_outside_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR, ST_WALK:
            begin
                if (last_col)
                begin
                    if (last_row)
                    begin
                        state_next = ST_IDLE;
                        if (report_reg)
                        begin
                            out_valid_next   = 1'b1;
                            out_color_next   = '0;
                            out_count_next   = count_reg;
                            out_outside_next = 1'b0;
                        end
                    end
                    else
                    begin
                        row_next  = COORD_W'(row_reg + 1'b1);
                        col_next  = x0_reg;
                        base_next = next_base;
                        addr_next = next_base;
                    end
                end
                else
                begin
                    col_next  = COORD_W'(col_reg + 1'b1);
                    addr_next = ADDR_W'(addr_reg + 1'b1);
                end
            end
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    case (q_job.kind)
                        JOB_WALK:
                        begin
                            state_next  = ST_WALK;
                            x0_next     = q_job.x0;
                            x1_next     = q_job.x1;
                            y1_next     = q_job.y1;
                            col_next    = q_job.x0;
                            row_next    = q_job.y0;
                            addr_next   = q_job.base;
                            base_next   = q_job.base;
                            color_next  = q_job.color;
                            count_next  = q_job.count;
                            report_next = 1'b1;
                        end
                        JOB_READ:
                        begin
                            state_next = ST_READ;
                            addr_next  = q_job.base;
                        end
                        default:
                        begin
                            out_valid_next   = 1'b1;
                            out_color_next   = '0;
                            out_count_next   = q_job.count;
                            out_outside_next = q_job.outside;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_RDATA;
            end
            ST_RDATA:
            begin
                state_next       = ST_IDLE;
                out_valid_next   = 1'b1;
                out_color_next   = mem_rdata;
                out_count_next   = '0;
                out_outside_next = 1'b0;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // reset starts a black fill over the whole screen with no result
            state_reg       <= ST_CLEAR;
            col_reg         <= '0;
            row_reg         <= '0;
            x0_reg          <= '0;
            x1_reg          <= COORD_W'(SCREEN_WIDTH);
            y1_reg          <= COORD_W'(SCREEN_HEIGHT);
            addr_reg        <= '0;
            base_reg        <= '0;
            color_reg       <= '0;
            count_reg       <= '0;
            report_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_color_reg   <= '0;
            out_count_reg   <= '0;
            out_outside_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            x0_reg          <= x0_next;
            x1_reg          <= x1_next;
            y1_reg          <= y1_next;
            addr_reg        <= addr_next;
            base_reg        <= base_next;
            color_reg       <= color_next;
            count_reg       <= count_next;
            report_reg      <= report_next;
            out_valid_reg   <= out_valid_next;
            out_color_reg   <= out_color_next;
            out_count_reg   <= out_count_next;
            out_outside_reg <= out_outside_next;
        end
    end

    // the result slot must be free when a reporting walk finishes
    a_slot_free_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && last_col && last_row) |-> (!out_valid_reg || pop))
        else $error("walk finished with result slot occupied");

    // every store write lands inside the screen
    a_addr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ({1'b0, addr_reg} < (ADDR_W + 1)'(DEPTH)))
        else $error("store write address out of range");

    // walk position stays inside the clipped extent
    a_walk_in_extent: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (col_reg < x1_reg) && (row_reg < y1_reg))
        else $error("walk position outside extent");

endmodule

// ===== hw/rtl/clipped_rect_fill_framebuffer.sv =====
// top level of the clipped rectangle fill frame store
// path: a request passes the front register and the queue entry, then in the back end
//   pixel or fill: one write per pixel, read: READ then RDATA state, no-op: result set from idle
// throughput: the back end takes a request off the queue only from idle and with the result
//   slot free, then a fill writes one pixel per cycle until its last pixel
// reset: asynchronous; afterwards a clearing pass writes black to all
//   SCREEN_WIDTH*SCREEN_HEIGHT entries, one per cycle, with full held high
module clipped_rect_fill_framebuffer
    import crf_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 256,
    parameter int SCREEN_HEIGHT = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    // request side
    input  logic               push,
    output logic               full,
    input  logic [1:0]         op,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] rect_width,
    input  logic signed [15:0] rect_height,
    input  logic [15:0]        pixel_color,
    // result side
    output logic               empty,
    input  logic               pop,
    output logic [15:0]        read_color,
    output logic [16:0]        pixels_written,
    output logic               outside
);

    // classified request from the front end to the queue
    logic job_push;
    job_t front_job;

    // queue to back end
    logic q_full;
    logic q_valid;
    logic q_pop;
    job_t q_job;

    // back end is running its post-reset clearing pass
    logic clearing;

    // front end: clip each request to the screen, work out the pixel count
    // and the starting store address, and sort it into walk, read or no-op
    crf_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .pixel_color (pixel_color),
        .hold        (clearing),
        .q_full      (q_full),
        .job_push    (job_push),
        .job         (front_job)
    );

    // short queue so the front end keeps taking requests during a long fill
    crf_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (front_job),
        .full  (q_full),
        .valid (q_valid),
        .pop   (q_pop),
        .rdata (q_job)
    );

    // back end: row/column walk over the frame store, reads, result register
    crf_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_job          (q_job),
        .q_pop          (q_pop),
        .clearing       (clearing),
        .empty          (empty),
        .pop            (pop),
        .read_color     (read_color),
        .pixels_written (pixels_written),
        .outside        (outside)
    );

endmodule
